### rtl/core/dcs_pkg.sv
// Package with shared types and constants of the dispense celebration sequencer.
package dcs_pkg;

    localparam int TIME_BITS_DEFAULT = 20;
    localparam int CFG_TIME_W        = 20;
    localparam int DEB_W             = 10;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 20;
    localparam int S_TDATA_W         = 8;
    localparam int M_TDATA_W         = 8;

    localparam logic HIGH = 1'b1;
    localparam logic LOW  = 1'b0;

    localparam logic LEVEL_PRESSED  = LOW;
    localparam logic LEVEL_RELEASED = HIGH;

    localparam logic [DEB_W-1:0] DEB_COUNT_MAX = {DEB_W{1'b1}};

    localparam logic [DEB_W-1:0]      DEBOUNCE_RESET   = 10'd30;
    localparam logic                  DROP_EN_RESET    = 1'b1;
    localparam logic [CFG_TIME_W-1:0] TIMEOUT_RESET    = 20'd10000;
    localparam logic [CFG_TIME_W-1:0] FIXED_RUN_RESET  = 20'd2000;
    localparam logic [CFG_TIME_W-1:0] MIN_CELEB_RESET  = 20'd5000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEBOUNCE  = 3'd0,
        CFG_DROP_EN   = 3'd1,
        CFG_TIMEOUT   = 3'd2,
        CFG_FIXED_RUN = 3'd3,
        CFG_MIN_CELEB = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PRESSED  = 3'd1,
        EV_JAMMED   = 3'd2,
        EV_DROPPED  = 3'd3,
        EV_TIMEOUT  = 3'd4,
        EV_PORTION  = 3'd5,
        EV_FINISHED = 3'd6
    } event_t;

    typedef enum logic {
        MODE_IDLE      = 1'b0,
        MODE_CELEBRATE = 1'b1
    } mode_t;

endpackage

### rtl/core/dispense_celebration_sequencer_unit.sv
// Top level of the dispense celebration sequencer: debounce, mode control and result register.
//
// Each transfer on the s_ channel is one millisecond tick and yields exactly one
// result transfer on the m_ channel. The block takes one tick per clock cycle:
// all debounce, timing and mode decisions are made in a single pass from the
// accepted tick into the result register, so the only limit on rate is the
// one-entry result register, which accepts a new tick whenever it is empty or
// being drained in the same cycle. Configuration writes on the cfg_ channel are
// always accepted and are meant to be made while the block is idle.
module dispense_celebration_sequencer_unit
    import dcs_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Bits from low: button_level, jam_gave_up, drop_seen, audio_busy, zero pad.
    input  logic [S_TDATA_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Bits from low: start_pulse, motor_stop_pulse, end_pulse, celebrating,
    // dispense_finished, event_code[2:0].
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CMP_W = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // Configuration registers.
    logic [DEB_W-1:0]      debounce_reg;
    logic                  drop_en_reg;
    logic [CFG_TIME_W-1:0] timeout_reg;
    logic [CFG_TIME_W-1:0] fixed_run_reg;
    logic [CFG_TIME_W-1:0] min_celeb_reg;

    // Sequencer state.
    mode_t                 mode_reg, mode_next;
    logic                  last_raw_reg, last_raw_next;
    logic                  stable_reg, stable_next;
    logic [DEB_W-1:0]      since_reg, since_next;
    logic [TIME_BITS-1:0]  elapsed_reg, elapsed_next;
    logic                  done_reg, done_next;

    // Result register.
    logic                  m_valid_reg;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;

    logic raw, jam, drop, audio;
    logic s_accept, cfg_accept;
    logic pressed;
    logic [TIME_BITS-1:0] elapsed_inc;
    logic [CMP_W-1:0]     elapsed_cmp;
    logic jam_end, drop_end, timeout_end, portion_end, disp_end, celeb_end;
    logic start_pulse, stop_pulse, end_pulse;
    event_t ev;

    assign raw   = s_tdata[0];
    assign jam   = s_tdata[1];
    assign drop  = s_tdata[2];
    assign audio = s_tdata[3];

    assign s_tready   = !m_valid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = HIGH;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;

    // Debounce: a raw change restarts the hold count, a steady level counts up to saturation.
    always_comb begin
        if (raw != last_raw_reg) begin
            last_raw_next = raw;
            since_next    = '0;
        end else begin
            last_raw_next = last_raw_reg;
            since_next    = (since_reg == DEB_COUNT_MAX) ? since_reg : since_reg + 1'b1;
        end
        if (since_next >= debounce_reg && raw != stable_reg) begin
            stable_next = raw;
            pressed     = (raw == LEVEL_PRESSED);
        end else begin
            stable_next = stable_reg;
            pressed     = LOW;
        end
    end

    // Dispense and celebration end conditions, evaluated on the incremented time.
    always_comb begin
        elapsed_inc = (elapsed_reg == TIME_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
        elapsed_cmp = CMP_W'(elapsed_inc);
        jam_end     = !done_reg && jam;
        drop_end    = !done_reg && !jam && drop_en_reg && drop;
        timeout_end = !done_reg && !jam && drop_en_reg && !drop
                      && (elapsed_cmp > CMP_W'(timeout_reg));
        portion_end = !done_reg && !jam && !drop_en_reg
                      && (elapsed_cmp > CMP_W'(fixed_run_reg));
        disp_end    = jam_end || drop_end || timeout_end || portion_end;
        celeb_end   = (done_reg || disp_end) && !audio
                      && (elapsed_cmp >= CMP_W'(min_celeb_reg));
    end

    // Next state.
    always_comb begin
        mode_next    = mode_reg;
        elapsed_next = elapsed_reg;
        done_next    = done_reg;
        unique case (mode_reg)
            MODE_IDLE: begin
                if (pressed) begin
                    mode_next    = MODE_CELEBRATE;
                    elapsed_next = '0;
                    done_next    = LOW;
                end
            end
            MODE_CELEBRATE: begin
                elapsed_next = elapsed_inc;
                if (disp_end) begin
                    done_next = HIGH;
                end
                if (celeb_end) begin
                    mode_next = MODE_IDLE;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    // Outputs of one tick.
    always_comb begin
        start_pulse = LOW;
        stop_pulse  = LOW;
        end_pulse   = LOW;
        ev          = EV_NONE;
        unique case (mode_reg)
            MODE_IDLE: begin
                if (pressed) begin
                    start_pulse = HIGH;
                    ev          = EV_PRESSED;
                end
            end
            MODE_CELEBRATE: begin
                stop_pulse = drop_end || timeout_end || portion_end;
                if (jam_end) begin
                    ev = EV_JAMMED;
                end else if (drop_end) begin
                    ev = EV_DROPPED;
                end else if (timeout_end) begin
                    ev = EV_TIMEOUT;
                end else if (portion_end) begin
                    ev = EV_PORTION;
                end
                if (celeb_end) begin
                    end_pulse = HIGH;
                    ev        = EV_FINISHED;
                end
            end
            default: begin
                ev = EV_NONE;
            end
        endcase
        m_data_next = {ev, done_next, mode_next, end_pulse, stop_pulse, start_pulse};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg  <= DEBOUNCE_RESET;
            drop_en_reg   <= DROP_EN_RESET;
            timeout_reg   <= TIMEOUT_RESET;
            fixed_run_reg <= FIXED_RUN_RESET;
            min_celeb_reg <= MIN_CELEB_RESET;
        end else if (cfg_accept) begin
            case (cfg_index)
                CFG_DEBOUNCE:  debounce_reg  <= cfg_data[DEB_W-1:0];
                CFG_DROP_EN:   drop_en_reg   <= cfg_data[0];
                CFG_TIMEOUT:   timeout_reg   <= cfg_data[CFG_TIME_W-1:0];
                CFG_FIXED_RUN: fixed_run_reg <= cfg_data[CFG_TIME_W-1:0];
                CFG_MIN_CELEB: min_celeb_reg <= cfg_data[CFG_TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            last_raw_reg <= LEVEL_RELEASED;
            stable_reg   <= LEVEL_RELEASED;
            since_reg    <= '0;
            elapsed_reg  <= '0;
            done_reg     <= LOW;
            m_valid_reg  <= LOW;
        end else begin
            if (s_accept) begin
                mode_reg     <= mode_next;
                last_raw_reg <= last_raw_next;
                stable_reg   <= stable_next;
                since_reg    <= since_next;
                elapsed_reg  <= elapsed_next;
                done_reg     <= done_next;
                m_valid_reg  <= HIGH;
            end else if (m_tready) begin
                m_valid_reg  <= LOW;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= m_data_next;
        end
    end

    // A start pulse always reports the celebrating mode and no finished dispense.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[0]) |-> (m_data_reg[3] && !m_data_reg[4]))
        else $error("start pulse without celebrating mode");

    // An end pulse returns to idle with dispensing over.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[2]) |-> (!m_data_reg[3] && m_data_reg[4]))
        else $error("end pulse with inconsistent mode");

    // The motor stop pulse is never given for a jam.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[1]) |-> (m_data_reg[7:5] != EV_JAMMED))
        else $error("motor stop pulse on jam");

    // Dispensing can only finish during a celebration.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && mode_reg == MODE_IDLE) |=> (!done_reg || $past(done_reg)))
        else $error("dispense finished while idle");

    // State holds while no tick is transferred.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> ($stable(elapsed_reg) && $stable(mode_reg)))
        else $error("sequencer state moved without a tick");

endmodule

### tb/dispense_celebration_sequencer_unit_test.sv
// Self-checking testbench for the dispense celebration sequencer unit.
module dispense_celebration_sequencer_unit_test
    import dcs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                      TB_TIME_BITS  = TIME_BITS_DEFAULT;
    localparam logic [TB_TIME_BITS-1:0] ELAPSED_MAX   = '1;
    localparam logic [CFG_TIME_W-1:0]   TIME_REG_MAX  = '1;
    localparam logic [DEB_W-1:0]        DEB_REG_MAX   = '1;
    localparam logic [DEB_W-1:0]        DEB_LONG      = 10'd120;
    localparam logic [CFG_INDEX_W-1:0]  CFG_SPARE_LO  = CFG_INDEX_W'(CFG_MIN_CELEB + 1);
    localparam logic [CFG_INDEX_W-1:0]  CFG_SPARE_HI  = '1;
    localparam int                      RANDOM_TICKS  = 380;

    typedef struct {
        logic button_level;
        logic jam_gave_up;
        logic drop_seen;
        logic audio_busy;
    } tick_in_t;

    typedef struct {
        logic   start_pulse;
        logic   motor_stop_pulse;
        logic   end_pulse;
        logic   celebrating;
        logic   dispense_finished;
        event_t event_code;
    } outcome_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    // Bits from low: button_level, jam_gave_up, drop_seen, audio_busy, zero pad.
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // Bits from low: start_pulse, motor_stop_pulse, end_pulse, celebrating,
    // dispense_finished, event_code[2:0].
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    dispense_celebration_sequencer_unit #(
        .TIME_BITS(TB_TIME_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Predicted sequencer state and register copies.
    logic [DEB_W-1:0]        reg_debounce;
    logic                    reg_drop_en;
    logic [CFG_TIME_W-1:0]   reg_timeout;
    logic [CFG_TIME_W-1:0]   reg_fixed_run;
    logic [CFG_TIME_W-1:0]   reg_min_celeb;
    mode_t                   mode;
    logic                    last_raw;
    logic                    stable_level;
    logic [DEB_W-1:0]        since_change;
    logic [TB_TIME_BITS-1:0] elapsed;
    logic                    done_flag;

    outcome_t tick_outcomes[$];
    bit       calm;
    int       fail_count;
    int       ticks_sent;
    int       results_checked;
    int       starts_predicted;
    int       settings_applied;
    int       event_tally[8];

    always #6 aclk = ~aclk;

    function automatic bit chance(input int n);
        return $urandom_range(0, n - 1) == 0;
    endfunction

    function automatic void reset_sequencer();
        reg_debounce  = DEBOUNCE_RESET;
        reg_drop_en   = DROP_EN_RESET;
        reg_timeout   = TIMEOUT_RESET;
        reg_fixed_run = FIXED_RUN_RESET;
        reg_min_celeb = MIN_CELEB_RESET;
        mode          = MODE_IDLE;
        last_raw      = LEVEL_RELEASED;
        stable_level  = LEVEL_RELEASED;
        since_change  = '0;
        elapsed       = '0;
        done_flag     = LOW;
    endfunction

    function automatic outcome_t step_sequencer(input tick_in_t t);
        outcome_t o;
        logic     pressed;
        o.start_pulse      = LOW;
        o.motor_stop_pulse = LOW;
        o.end_pulse        = LOW;
        o.event_code       = EV_NONE;
        pressed            = LOW;

        // Debounce: a raw change restarts the hold count, which saturates.
        if (t.button_level != last_raw) begin
            last_raw     = t.button_level;
            since_change = '0;
        end else if (since_change != DEB_COUNT_MAX) begin
            since_change = since_change + 1'b1;
        end
        if (since_change >= reg_debounce && t.button_level != stable_level) begin
            stable_level = t.button_level;
            pressed      = (stable_level == LEVEL_PRESSED);
        end

        if (mode == MODE_IDLE) begin
            if (pressed) begin
                mode          = MODE_CELEBRATE;
                elapsed       = '0;
                done_flag     = LOW;
                o.start_pulse = HIGH;
                o.event_code  = EV_PRESSED;
                starts_predicted++;
            end
        end else begin
            if (elapsed != ELAPSED_MAX) begin
                elapsed = elapsed + 1'b1;
            end
            if (!done_flag) begin
                if (t.jam_gave_up) begin
                    done_flag    = HIGH;
                    o.event_code = EV_JAMMED;
                end else if (reg_drop_en) begin
                    if (t.drop_seen) begin
                        done_flag          = HIGH;
                        o.motor_stop_pulse = HIGH;
                        o.event_code       = EV_DROPPED;
                    end else if (elapsed > reg_timeout) begin
                        done_flag          = HIGH;
                        o.motor_stop_pulse = HIGH;
                        o.event_code       = EV_TIMEOUT;
                    end
                end else if (elapsed > reg_fixed_run) begin
                    done_flag          = HIGH;
                    o.motor_stop_pulse = HIGH;
                    o.event_code       = EV_PORTION;
                end
            end
            if (done_flag && !t.audio_busy && elapsed >= reg_min_celeb) begin
                mode         = MODE_IDLE;
                o.end_pulse  = HIGH;
                o.event_code = EV_FINISHED;
            end
        end

        o.celebrating       = (mode == MODE_CELEBRATE);
        o.dispense_finished = done_flag;
        return o;
    endfunction

    function automatic void check_field(input string label, input logic [2:0] want_v,
                                        input logic [2:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected %0d, actual %0d", label, want_v, got_v);
            fail_count++;
        end
    endfunction

    // Each call starts at a falling edge and returns at the falling edge after the
    // transfer, with tvalid still high so a back-to-back tick needs no toggle.
    task automatic send_tick(input logic button, input logic jam, input logic drop,
                             input logic audio);
        tick_in_t t;
        t.button_level = button;
        t.jam_gave_up  = jam;
        t.drop_seen    = drop;
        t.audio_busy   = audio;
        if (!calm && chance(8)) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - 4){1'b0}}, audio, drop, jam, button};
        do @(posedge aclk); while (!s_tready);
        tick_outcomes.push_back(step_sequencer(t));
        ticks_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (tick_outcomes.size() != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_DEBOUNCE:  reg_debounce  = value[DEB_W-1:0];
            CFG_DROP_EN:   reg_drop_en   = value[0];
            CFG_TIMEOUT:   reg_timeout   = value[CFG_TIME_W-1:0];
            CFG_FIXED_RUN: reg_fixed_run = value[CFG_TIME_W-1:0];
            CFG_MIN_CELEB: reg_min_celeb = value[CFG_TIME_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Writes every register once the block has returned all results. Unused bits
    // of the narrow registers carry random junk, and one unused index is written.
    task automatic program_settings(input logic [DEB_W-1:0] deb, input logic drop_en,
                                    input logic [CFG_TIME_W-1:0] timeout,
                                    input logic [CFG_TIME_W-1:0] fixed_run,
                                    input logic [CFG_TIME_W-1:0] min_celeb);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        drain_results();
        write_reg(CFG_DEBOUNCE, {junk[CFG_DATA_W-1:DEB_W], deb});
        write_reg(CFG_DROP_EN, {junk[CFG_DATA_W-1:1], drop_en});
        write_reg(CFG_TIMEOUT, timeout);
        write_reg(CFG_FIXED_RUN, fixed_run);
        write_reg(CFG_MIN_CELEB, min_celeb);
        write_reg(CFG_INDEX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                  CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        settings_applied++;
        @(negedge aclk);
    endtask

    // One well-formed press cycle: release long enough to settle, press long
    // enough to be accepted, then a celebration body with sparse events.
    task automatic run_session(input int deb);
        int hold;
        int body;
        int audio_left;
        hold = deb + $urandom_range(1, 3);
        repeat (hold) send_tick(LEVEL_RELEASED, chance(30), chance(8), chance(2));
        if (chance(4)) begin
            send_tick(LEVEL_PRESSED, LOW, LOW, LOW);
            send_tick(LEVEL_RELEASED, LOW, LOW, LOW);
        end
        hold = deb + $urandom_range(1, 3);
        repeat (hold) send_tick(LEVEL_PRESSED, chance(30), chance(8), chance(2));
        body       = $urandom_range(3, 40);
        audio_left = $urandom_range(0, body);
        for (int i = 0; i < body; i++) begin
            send_tick(chance(10) ? LEVEL_PRESSED : LEVEL_RELEASED, chance(25), chance(10),
                      i < audio_left);
        end
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(4, 16)) begin
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_reset_values();
        // With the default 30 tick debounce these short presses must not count.
        send_tick(LEVEL_RELEASED, LOW, LOW, LOW);
        repeat (4) send_tick(LEVEL_PRESSED, HIGH, HIGH, HIGH);
        send_tick(LEVEL_RELEASED, HIGH, LOW, HIGH);
    endtask

    task automatic test_drop_and_audio();
        program_settings('0, HIGH, 20, 5, 3);
        send_tick(LEVEL_PRESSED, LOW, LOW, LOW);
        send_tick(LEVEL_RELEASED, LOW, HIGH, HIGH);
        // A press while celebrating is ignored.
        send_tick(LEVEL_PRESSED, LOW, LOW, HIGH);
        send_tick(LEVEL_RELEASED, LOW, LOW, LOW);
    endtask

    task automatic test_jam_and_same_tick_end();
        program_settings('0, HIGH, 20, 5, 0);
        // Jam wins over a drop in the same tick, and the celebration ends at once.
        send_tick(LEVEL_PRESSED, LOW, LOW, LOW);
        send_tick(LEVEL_RELEASED, HIGH, HIGH, LOW);
        send_tick(LEVEL_PRESSED, LOW, LOW, LOW);
        send_tick(LEVEL_RELEASED, LOW, HIGH, LOW);
        send_tick(LEVEL_PRESSED, LOW, LOW, LOW);
        send_tick(LEVEL_RELEASED, HIGH, LOW, HIGH);
        send_tick(LEVEL_RELEASED, LOW, LOW, LOW);
    endtask

    task automatic test_timeout_and_fixed_run();
        program_settings('0, HIGH, 0, 5, 2);
        send_tick(LEVEL_PRESSED, LOW, LOW, LOW);
        send_tick(LEVEL_RELEASED, LOW, LOW, LOW);
        send_tick(LEVEL_RELEASED, LOW, LOW, LOW);
        // Without the drop sensor a drop is ignored and the fixed run time applies.
        program_settings('0, LOW, 20, 1, 0);
        send_tick(LEVEL_PRESSED, LOW, LOW, LOW);
        send_tick(LEVEL_RELEASED, LOW, HIGH, LOW);
        send_tick(LEVEL_RELEASED, LOW, LOW, LOW);
    endtask

    task automatic test_register_extremes();
        program_settings('0, HIGH, TIME_REG_MAX, TIME_REG_MAX, TIME_REG_MAX);
        send_tick(LEVEL_PRESSED, LOW, LOW, LOW);
        repeat (3) send_tick(LEVEL_RELEASED, LOW, LOW, LOW);
        send_tick(LEVEL_RELEASED, LOW, HIGH, LOW);
        // Lowering the minimum mid-celebration lets the next quiet tick end it.
        program_settings('0, LOW, '0, '0, '0);
        send_tick(LEVEL_RELEASED, LOW, LOW, LOW);
    endtask

    task automatic test_debounce_bounce();
        program_settings(3, HIGH, 10, 5, 4);
        send_tick(LEVEL_PRESSED, LOW, LOW, LOW);
        send_tick(LEVEL_RELEASED, LOW, LOW, LOW);
        repeat (4) send_tick(LEVEL_PRESSED, LOW, LOW, LOW);
    endtask

    task automatic test_long_debounce();
        // At the largest hold time a press of a few dozen ticks is still ignored.
        program_settings(DEB_REG_MAX, HIGH, 40, 5, 10);
        send_tick(LEVEL_RELEASED, LOW, LOW, LOW);
        repeat (24) send_tick(LEVEL_PRESSED, LOW, LOW, LOW);
        program_settings(DEB_LONG, HIGH, 40, 5, 10);
        run_session(DEB_LONG);
    endtask

    task automatic test_random_sessions();
        int                    random_start;
        logic [DEB_W-1:0]      deb;
        logic [CFG_TIME_W-1:0] timeout;
        logic [CFG_TIME_W-1:0] fixed_run;
        logic [CFG_TIME_W-1:0] min_celeb;
        random_start = ticks_sent;
        while (ticks_sent - random_start < RANDOM_TICKS) begin
            if (ticks_sent - random_start >= RANDOM_TICKS * 4 / 5) begin
                calm = 1'b1;
            end
            deb       = chance(4) ? '0 : DEB_W'($urandom_range(1, 4));
            timeout   = chance(6) ? (chance(2) ? '0 : TIME_REG_MAX)
                                  : CFG_TIME_W'($urandom_range(0, 30));
            fixed_run = chance(6) ? (chance(2) ? '0 : TIME_REG_MAX)
                                  : CFG_TIME_W'($urandom_range(0, 30));
            min_celeb = chance(8) ? (chance(3) ? TIME_REG_MAX : '0)
                                  : CFG_TIME_W'($urandom_range(0, 40));
            program_settings(deb, 1'($urandom_range(0, 1)), timeout, fixed_run, min_celeb);
            repeat ($urandom_range(2, 5)) begin
                if (chance(5)) begin
                    noise_burst();
                end else begin
                    run_session(deb);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        outcome_t             want;
        logic [M_TDATA_W-1:0] got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (tick_outcomes.size() == 0) begin
                $error("result 0x%02h arrived with no tick outstanding", got);
                fail_count++;
            end else begin
                want = tick_outcomes.pop_front();
                results_checked++;
                event_tally[got[7:5]]++;
                check_field("start_pulse", want.start_pulse, got[0]);
                check_field("motor_stop_pulse", want.motor_stop_pulse, got[1]);
                check_field("end_pulse", want.end_pulse, got[2]);
                check_field("celebrating", want.celebrating, got[3]);
                check_field("dispense_finished", want.dispense_finished, got[4]);
                check_field("event_code", want.event_code, got[7:5]);
            end
        end
    end

    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!calm && chance(10)) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DEBOUNCE;
        cfg_data  = '0;
        calm      = 1'b0;
        reset_sequencer();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_values();
        test_drop_and_audio();
        test_jam_and_same_tick_end();
        test_timeout_and_fixed_run();
        test_register_extremes();
        test_debounce_bounce();
        test_long_debounce();
        test_random_sessions();

        drain_results();
        repeat (8) @(negedge aclk);
        if (tick_outcomes.size() != 0) begin
            $error("%0d expected results never arrived", tick_outcomes.size());
            fail_count++;
        end
        $display("tb: %0d ticks checked under %0d register settings, %0d celebrations begun",
                 results_checked, settings_applied, starts_predicted);
        $display("tb: endings seen: drop %0d, timeout %0d, fixed run %0d, jam %0d, done %0d",
                 event_tally[EV_DROPPED], event_tally[EV_TIMEOUT], event_tally[EV_PORTION],
                 event_tally[EV_JAMMED], event_tally[EV_FINISHED]);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
